// File: hw/rtl/best_fit_heap_allocator_core_defines.svh
// Assertion macros shared by the heap allocator RTL.
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("heap allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define BFHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("heap allocator assertion failed");

`endif

// File: hw/rtl/bfha_pkg.sv
// Shared types, codes and default sizes of the heap allocator.
package bfha_pkg;

  localparam int CHUNK_BYTES_DEF   = 8192;
  localparam int HEADER_BYTES_DEF  = 16;
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int MAX_CHUNKS_DEF    = 8;

  localparam int FIELD_W   = 16;
  localparam int LIMIT_W   = 4;
  localparam int STATUS_W  = 2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_OOM     = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] uaddr;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] addr;
    status_e            status;
  } rsp_t;

endpackage

// File: hw/rtl/bfha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: hw/rtl/bfha_seq.sv
// Sequencer over the free and used tables: scans, splits, merges and shifts.
`include "best_fit_heap_allocator_core_defines.svh"
module bfha_seq #(
  parameter int CHUNK_BYTES   = bfha_pkg::CHUNK_BYTES_DEF,
  parameter int HEADER_BYTES  = bfha_pkg::HEADER_BYTES_DEF,
  parameter int TABLE_ENTRIES = bfha_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CHUNKS    = bfha_pkg::MAX_CHUNKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  bfha_pkg::cmd_t               cmd_i,
  output logic                         cmd_ready_o,
  output logic                         rsp_valid_o,
  output bfha_pkg::rsp_t               rsp_o,
  input  logic                         rsp_ready_i,
  input  logic [bfha_pkg::LIMIT_W-1:0] chunk_limit_i
);
  import bfha_pkg::*;

  localparam int SW  = $clog2(MAX_CHUNKS * CHUNK_BYTES);
  localparam int AW  = ((SW > FIELD_W) ? SW : FIELD_W) + 2;
  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = IW + 1;
  localparam int GW  = $clog2(MAX_CHUNKS + 1);
  localparam int XW  = GW + LIMIT_W + 1;
  localparam int EW  = 2 * SW;
  localparam logic [AW-1:0] HB    = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] CB    = AW'(CHUNK_BYTES);
  localparam logic [AW-1:0] MAXSZ = AW'(CHUNK_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] TE    = CW'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_USCAN, S_FSCAN, S_ADEC, S_TAKE, S_FDEC, S_UMOVE, S_SHDN, S_SHUP, S_DONE
  } state_e;

  state_e state_q;
  op_e    op_q;
  logic [AW-1:0] sz_q, ua_q, key_q, top_q;
  logic [CW-1:0] fc_q, uc_q, cnt_q, ins_idx_q;
  logic [GW-1:0] grown_q;
  logic          pv_q;
  logic [IW-1:0] pidx_q;
  logic          ex_q, bt_q, lft_q, rgt_q, ins_q, um_q;
  logic [IW-1:0] ex_idx_q, bt_idx_q, lft_idx_q, rgt_idx_q, u_idx_q, b_idx_q;
  logic [AW-1:0] ex_st_q, ex_ln_q, bt_st_q, bt_ln_q, lft_st_q, lft_ln_q, rgt_ln_q;
  logic [AW-1:0] u_st_q, u_ln_q, u_end_q, b_st_q, b_ln_q;
  logic          b_new_q;
  logic [FIELD_W-1:0] res_addr_q;
  status_e       res_st_q;

  logic          f_we, u_we;
  logic [IW-1:0] f_waddr, f_raddr, u_waddr, u_raddr;
  logic [EW-1:0] f_wdata, u_wdata, f_rdata, u_rdata;
  logic [AW-1:0] f_st, f_ln, f_end, u_st, u_ln;
  logic          split;
  logic [AW-1:0] st_w, ln_w;
  logic [CW-1:0] cnt_m1, uc_m1;
  logic          oom;

  bfha_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_free_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  bfha_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_used_ram (
    .clk_i, .we_i(u_we), .waddr_i(u_waddr), .wdata_i(u_wdata),
    .raddr_i(u_raddr), .rdata_o(u_rdata)
  );

  assign f_st   = AW'(f_rdata[SW-1:0]);
  assign f_ln   = AW'(f_rdata[EW-1:SW]);
  assign f_end  = f_st + HB + f_ln;
  assign u_st   = AW'(u_rdata[SW-1:0]);
  assign u_ln   = AW'(u_rdata[EW-1:SW]);
  assign split  = b_ln_q >= sz_q + HB + AW'(1);
  assign st_w   = split ? (b_st_q + b_ln_q - sz_q) : b_st_q;
  assign ln_w   = split ? sz_q : b_ln_q;
  assign cnt_m1 = cnt_q - CW'(1);
  assign uc_m1  = uc_q - CW'(1);
  assign oom    = (XW'(grown_q) >= XW'(chunk_limit_i)) || (XW'(grown_q) >= XW'(MAX_CHUNKS));

  always_comb begin
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    f_raddr = cnt_q[IW-1:0];
    u_we    = 1'b0;
    u_waddr = '0;
    u_wdata = '0;
    u_raddr = cnt_q[IW-1:0];
    case (state_q)
      S_TAKE: begin
        if (split) begin
          f_we    = 1'b1;
          f_waddr = b_idx_q;
          f_wdata = {SW'(b_ln_q - sz_q - HB), SW'(b_st_q)};
        end
        u_we    = 1'b1;
        u_waddr = uc_q[IW-1:0];
        u_wdata = {SW'(ln_w), SW'(st_w)};
      end
      S_FDEC: begin
        u_raddr = uc_m1[IW-1:0];
      end
      S_UMOVE: begin
        u_we    = 1'b1;
        u_waddr = u_idx_q;
        u_wdata = u_rdata;
        if (lft_q && rgt_q) begin
          f_we    = 1'b1;
          f_waddr = lft_idx_q;
          f_wdata = {SW'(lft_ln_q + HB + u_ln_q + HB + rgt_ln_q), SW'(lft_st_q)};
        end else if (lft_q) begin
          f_we    = 1'b1;
          f_waddr = lft_idx_q;
          f_wdata = {SW'(lft_ln_q + HB + u_ln_q), SW'(lft_st_q)};
        end else if (rgt_q) begin
          f_we    = 1'b1;
          f_waddr = rgt_idx_q;
          f_wdata = {SW'(rgt_ln_q + HB + u_ln_q), SW'(u_st_q)};
        end
      end
      S_SHDN: begin
        if (pv_q) begin
          f_we    = 1'b1;
          f_waddr = pidx_q - IW'(1);
          f_wdata = f_rdata;
        end
      end
      S_SHUP: begin
        f_raddr = cnt_m1[IW-1:0];
        if (pv_q) begin
          f_we    = 1'b1;
          f_waddr = pidx_q + IW'(1);
          f_wdata = f_rdata;
        end else if (cnt_q == ins_idx_q) begin
          f_we    = 1'b1;
          f_waddr = ins_idx_q[IW-1:0];
          f_wdata = {SW'(u_ln_q), SW'(u_st_q)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_ALLOC;
      sz_q       <= '0;
      ua_q       <= '0;
      key_q      <= '0;
      top_q      <= '0;
      fc_q       <= '0;
      uc_q       <= '0;
      cnt_q      <= '0;
      ins_idx_q  <= '0;
      grown_q    <= '0;
      pv_q       <= 1'b0;
      pidx_q     <= '0;
      ex_q       <= 1'b0;
      bt_q       <= 1'b0;
      lft_q      <= 1'b0;
      rgt_q      <= 1'b0;
      ins_q      <= 1'b0;
      um_q       <= 1'b0;
      ex_idx_q   <= '0;
      bt_idx_q   <= '0;
      lft_idx_q  <= '0;
      rgt_idx_q  <= '0;
      u_idx_q    <= '0;
      b_idx_q    <= '0;
      ex_st_q    <= '0;
      ex_ln_q    <= '0;
      bt_st_q    <= '0;
      bt_ln_q    <= '0;
      lft_st_q   <= '0;
      lft_ln_q   <= '0;
      rgt_ln_q   <= '0;
      u_st_q     <= '0;
      u_ln_q     <= '0;
      u_end_q    <= '0;
      b_st_q     <= '0;
      b_ln_q     <= '0;
      b_new_q    <= 1'b0;
      res_addr_q <= '0;
      res_st_q   <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            op_q       <= cmd_i.op;
            sz_q       <= AW'(cmd_i.size);
            ua_q       <= AW'(cmd_i.uaddr);
            res_addr_q <= '0;
            res_st_q   <= ST_OK;
            cnt_q      <= '0;
            pv_q       <= 1'b0;
            ex_q       <= 1'b0;
            bt_q       <= 1'b0;
            lft_q      <= 1'b0;
            rgt_q      <= 1'b0;
            ins_q      <= 1'b0;
            um_q       <= 1'b0;
            ins_idx_q  <= fc_q;
            key_q      <= top_q;
            if (cmd_i.op == OP_ALLOC) begin
              if (cmd_i.size == '0) begin
                state_q <= S_DONE;
              end else if (AW'(cmd_i.size) > MAXSZ) begin
                res_st_q <= ST_TOO_BIG;
                state_q  <= S_DONE;
              end else if (uc_q >= TE) begin
                res_st_q <= ST_FULL;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_FSCAN;
              end
            end else begin
              state_q <= (cmd_i.uaddr == '0) ? S_DONE : S_USCAN;
            end
          end
        end
        S_USCAN: begin
          if (cnt_q < uc_q) begin
            cnt_q  <= cnt_q + CW'(1);
            pv_q   <= 1'b1;
            pidx_q <= cnt_q[IW-1:0];
          end else begin
            pv_q <= 1'b0;
          end
          if (pv_q && !um_q && (u_st + HB == ua_q)) begin
            um_q    <= 1'b1;
            u_idx_q <= pidx_q;
            u_st_q  <= u_st;
            u_ln_q  <= u_ln;
            u_end_q <= u_st + HB + u_ln;
            key_q   <= u_st;
          end
          if (!pv_q && cnt_q == uc_q) begin
            cnt_q   <= '0;
            state_q <= um_q ? S_FSCAN : S_DONE;
          end
        end
        S_FSCAN: begin
          if (cnt_q < fc_q) begin
            cnt_q  <= cnt_q + CW'(1);
            pv_q   <= 1'b1;
            pidx_q <= cnt_q[IW-1:0];
          end else begin
            pv_q <= 1'b0;
          end
          if (pv_q) begin
            if (!ex_q && f_ln == sz_q) begin
              ex_q     <= 1'b1;
              ex_idx_q <= pidx_q;
              ex_st_q  <= f_st;
              ex_ln_q  <= f_ln;
            end
            if (f_ln > sz_q && (!bt_q || f_ln < bt_ln_q)) begin
              bt_q     <= 1'b1;
              bt_idx_q <= pidx_q;
              bt_st_q  <= f_st;
              bt_ln_q  <= f_ln;
            end
            if (!lft_q && f_end == key_q) begin
              lft_q     <= 1'b1;
              lft_idx_q <= pidx_q;
              lft_st_q  <= f_st;
              lft_ln_q  <= f_ln;
            end
            if (!rgt_q && f_st == u_end_q) begin
              rgt_q     <= 1'b1;
              rgt_idx_q <= pidx_q;
              rgt_ln_q  <= f_ln;
            end
            if (!ins_q && f_st >= u_st_q) begin
              ins_q     <= 1'b1;
              ins_idx_q <= CW'(pidx_q);
            end
          end
          if (!pv_q && cnt_q == fc_q) begin
            state_q <= (op_q == OP_ALLOC) ? S_ADEC : S_FDEC;
          end
        end
        S_ADEC: begin
          b_new_q <= 1'b0;
          if (ex_q) begin
            b_idx_q <= ex_idx_q;
            b_st_q  <= ex_st_q;
            b_ln_q  <= ex_ln_q;
            state_q <= S_TAKE;
          end else if (bt_q) begin
            b_idx_q <= bt_idx_q;
            b_st_q  <= bt_st_q;
            b_ln_q  <= bt_ln_q;
            state_q <= S_TAKE;
          end else if (oom) begin
            res_st_q <= ST_OOM;
            state_q  <= S_DONE;
          end else if (lft_q) begin
            b_idx_q <= lft_idx_q;
            b_st_q  <= lft_st_q;
            b_ln_q  <= lft_ln_q + CB;
            grown_q <= grown_q + GW'(1);
            top_q   <= top_q + CB;
            state_q <= S_TAKE;
          end else if (fc_q >= TE) begin
            res_st_q <= ST_FULL;
            state_q  <= S_DONE;
          end else begin
            b_new_q <= 1'b1;
            b_idx_q <= fc_q[IW-1:0];
            b_st_q  <= top_q;
            b_ln_q  <= MAXSZ;
            grown_q <= grown_q + GW'(1);
            top_q   <= top_q + CB;
            state_q <= S_TAKE;
          end
        end
        S_TAKE: begin
          uc_q       <= uc_q + CW'(1);
          res_addr_q <= FIELD_W'(st_w + HB);
          cnt_q      <= CW'(b_idx_q) + CW'(1);
          pv_q       <= 1'b0;
          if (split) begin
            if (b_new_q) begin
              fc_q <= fc_q + CW'(1);
            end
            state_q <= S_DONE;
          end else begin
            state_q <= b_new_q ? S_DONE : S_SHDN;
          end
        end
        S_FDEC: begin
          if (!lft_q && !rgt_q && fc_q >= TE) begin
            res_st_q <= ST_FULL;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_UMOVE;
          end
        end
        S_UMOVE: begin
          uc_q <= uc_m1;
          pv_q <= 1'b0;
          if (lft_q && rgt_q) begin
            cnt_q   <= CW'(rgt_idx_q) + CW'(1);
            state_q <= S_SHDN;
          end else if (lft_q || rgt_q) begin
            state_q <= S_DONE;
          end else begin
            cnt_q   <= fc_q;
            state_q <= S_SHUP;
          end
        end
        S_SHDN: begin
          if (cnt_q < fc_q) begin
            cnt_q  <= cnt_q + CW'(1);
            pv_q   <= 1'b1;
            pidx_q <= cnt_q[IW-1:0];
          end else begin
            pv_q <= 1'b0;
          end
          if (!pv_q && cnt_q == fc_q) begin
            fc_q    <= fc_q - CW'(1);
            state_q <= S_DONE;
          end
        end
        S_SHUP: begin
          if (cnt_q > ins_idx_q) begin
            cnt_q  <= cnt_m1;
            pv_q   <= 1'b1;
            pidx_q <= cnt_m1[IW-1:0];
          end else begin
            pv_q <= 1'b0;
          end
          if (!pv_q && cnt_q == ins_idx_q) begin
            fc_q    <= fc_q + CW'(1);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_ready_o   = (state_q == S_IDLE);
  assign rsp_valid_o   = (state_q == S_DONE);
  assign rsp_o.addr    = res_addr_q;
  assign rsp_o.status  = res_st_q;

  `BFHA_ASSERT_IMP(a_fc_bound, clk_i, rst_ni, 1'b1, fc_q <= TE)
  `BFHA_ASSERT_IMP(a_grown_bound, clk_i, rst_ni, 1'b1, grown_q <= GW'(MAX_CHUNKS))
  `BFHA_ASSERT_IMP(a_take_room, clk_i, rst_ni, state_q == S_TAKE, uc_q < TE)
  `BFHA_ASSERT_NXT(a_idle_hold, clk_i, rst_ni, state_q == S_IDLE && !cmd_valid_i, $stable(uc_q) && $stable(fc_q))
endmodule

// File: hw/rtl/best_fit_heap_allocator_core.sv
// Best-fit heap allocator top level: stream ports, limit register, result register.
// Each word is an allocate or a free; one result word comes back per input word.
// An allocate scans the free table once and then takes a block; removing an
// exhausted free block shifts the rest of the table down, one entry a cycle.
// A free scans the used table, then the free table, and an insert or a merge
// of both neighbors shifts the free table by one entry a cycle. The time an
// item takes grows with the fill of the tables (64 entries by default) and is
// set by the single read port of each table RAM. A result waits in an output
// register while the next word is taken in. No clearing pass after reset.
module best_fit_heap_allocator_core #(
  parameter int CHUNK_BYTES   = bfha_pkg::CHUNK_BYTES_DEF,
  parameter int HEADER_BYTES  = bfha_pkg::HEADER_BYTES_DEF,
  parameter int TABLE_ENTRIES = bfha_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CHUNKS    = bfha_pkg::MAX_CHUNKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*bfha_pkg::FIELD_W-1:0] s_axis_tdata,  // request_size, user_address
  input  logic                          s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bfha_pkg::FIELD_W-1:0]  m_axis_tdata,  // result_address
  output logic [bfha_pkg::STATUS_W-1:0] m_axis_tuser,  // status
  input  logic                          cfg_we_i,
  input  logic [bfha_pkg::LIMIT_W-1:0]  cfg_wdata_i
);
  import bfha_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               m_valid_q;
  rsp_t               m_rsp_q;
  cmd_t               cmd;
  logic               rsp_valid, rsp_ready;
  rsp_t               rsp;

  assign cmd.op    = op_e'(s_axis_tuser);
  assign cmd.size  = s_axis_tdata[FIELD_W-1:0];
  assign cmd.uaddr = s_axis_tdata[2*FIELD_W-1:FIELD_W];
  assign rsp_ready = !m_valid_q || m_axis_tready;

  bfha_seq #(
    .CHUNK_BYTES(CHUNK_BYTES), .HEADER_BYTES(HEADER_BYTES),
    .TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CHUNKS(MAX_CHUNKS)
  ) u_seq (
    .clk_i, .rst_ni,
    .cmd_valid_i(s_axis_tvalid), .cmd_i(cmd), .cmd_ready_o(s_axis_tready),
    .rsp_valid_o(rsp_valid), .rsp_o(rsp), .rsp_ready_i(rsp_ready),
    .chunk_limit_i(limit_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RESET;
      m_valid_q <= 1'b0;
      m_rsp_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (rsp_valid && rsp_ready) begin
        m_valid_q <= 1'b1;
        m_rsp_q   <= rsp;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_rsp_q.addr;
  assign m_axis_tuser  = m_rsp_q.status;
endmodule
